>>> design/rtms_pkg.sv
// Shared types and codes for the right-triangle missing-side block.
// No dependencies; every other file of the block but rtms_req_if imports this package.
`timescale 1ns / 1ps

package rtms_pkg;

	// Width of the side value and of the code fields in a result word
	localparam int SIDE_BITS = 16;
	localparam int CODE_BITS = 2;

	// Which side was computed
	localparam logic [CODE_BITS-1:0] SIDE_OPP = 2'd0;
	localparam logic [CODE_BITS-1:0] SIDE_ADJ = 2'd1;
	localparam logic [CODE_BITS-1:0] SIDE_HYP = 2'd2;

	// Result status
	localparam logic [CODE_BITS-1:0] ST_OK     = 2'd0;
	localparam logic [CODE_BITS-1:0] ST_PARAM  = 2'd1;
	localparam logic [CODE_BITS-1:0] ST_LEG_GT = 2'd2;

	// Sideband that rides along the square-root pipeline
	typedef struct packed {
		logic [CODE_BITS-1:0] which;
		logic [CODE_BITS-1:0] status;
	} rtms_tag_t;

endpackage

>>> design/rtms_req_if.sv
// Request channel: valid/ready handshake carrying three signed side lengths.
// No dependencies.
`timescale 1ns / 1ps

interface rtms_req_if #(
	parameter int LENGTH_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [LENGTH_BITS-1:0] opposite_leg;
	logic signed [LENGTH_BITS-1:0] adjacent_leg;
	logic signed [LENGTH_BITS-1:0] hypotenuse_len;

	modport source (output valid, opposite_leg, adjacent_leg, hypotenuse_len, input ready);
	modport sink (input valid, opposite_leg, adjacent_leg, hypotenuse_len, output ready);
endinterface

>>> design/rtms_rsp_if.sv
// Response channel: valid/ready handshake carrying the computed side and codes.
// Depends on rtms_pkg for field widths.
`timescale 1ns / 1ps

interface rtms_rsp_if
	import rtms_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [SIDE_BITS-1:0] side_value;
	logic [CODE_BITS-1:0] which_side;
	logic [CODE_BITS-1:0] status_code;

	modport source (output valid, side_value, which_side, status_code, input ready);
	modport sink (input valid, side_value, which_side, status_code, output ready);
endinterface

>>> design/rtms_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on rtms_pkg for the sideband tag type.
`timescale 1ns / 1ps

module rtms_isqrt
	import rtms_pkg::*;
#(
	parameter int ROOT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [2*ROOT_BITS-1:0] in_rad,
	input  rtms_tag_t              in_tag,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ROOT_BITS-1:0]   out_root,
	output rtms_tag_t              out_tag
);

	localparam int RW   = 2 * ROOT_BITS;
	localparam int REMW = ROOT_BITS + 2;
	localparam int TW   = REMW + 2;

	// index 0 is the input, index k+1 is the register of stage k
	logic                 valid_p [0:ROOT_BITS];
	logic [RW-1:0]        rad_p   [0:ROOT_BITS];
	logic [REMW-1:0]      rem_p   [0:ROOT_BITS];
	logic [ROOT_BITS-1:0] root_p  [0:ROOT_BITS];
	rtms_tag_t            tag_p   [0:ROOT_BITS];
	logic                 adv     [0:ROOT_BITS];

	assign valid_p[0] = in_valid;
	assign rad_p[0]   = in_rad;
	assign rem_p[0]   = '0;
	assign root_p[0]  = '0;
	assign tag_p[0]   = in_tag;
	assign adv[ROOT_BITS] = out_ready;
	assign in_ready = adv[0];

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
		logic                 valid_s;
		logic [RW-1:0]        rad_s;
		logic [REMW-1:0]      rem_s;
		logic [ROOT_BITS-1:0] root_s;
		rtms_tag_t            tag_s;
		logic [TW-1:0]        cur;
		logic [TW-1:0]        trial;
		logic                 ge;
		logic [TW-1:0]        diff;

		// a stage moves when it is empty or the next one moves
		assign adv[k] = !valid_s || adv[k+1];

		// bring down two radicand bits and try root*4+1
		always_comb begin
			cur   = {rem_p[k], rad_p[k][RW-1 -: 2]};
			trial = TW'({root_p[k], 2'b01});
			ge    = (cur >= trial);
			diff  = cur - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s <= 1'b0;
			end else if (adv[k]) begin
				valid_s <= valid_p[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rad_s  <= {rad_p[k][RW-3:0], 2'b00};
				rem_s  <= ge ? diff[REMW-1:0] : cur[REMW-1:0];
				root_s <= {root_p[k][ROOT_BITS-2:0], ge};
				tag_s  <= tag_p[k];
			end
		end

		assign valid_p[k+1] = valid_s;
		assign rad_p[k+1]   = rad_s;
		assign rem_p[k+1]   = rem_s;
		assign root_p[k+1]  = root_s;
		assign tag_p[k+1]   = tag_s;
	end

	assign out_valid = valid_p[ROOT_BITS];
	assign out_root  = root_p[ROOT_BITS];
	assign out_tag   = tag_p[ROOT_BITS];

	// remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_p[ROOT_BITS] |-> ({1'b0, rem_p[ROOT_BITS]} <= {2'b00, root_p[ROOT_BITS], 1'b0}))
		else $error("isqrt remainder out of range");

	// first stage yields a single root bit
	a_first_root: assert property (@(posedge clk) disable iff (!arst_n)
		valid_p[1] |-> (root_p[1][ROOT_BITS-1:1] == '0))
		else $error("isqrt first stage root too wide");

endmodule

>>> design/right_triangle_missing_side.sv
// Top level of the right-triangle missing-side block.
// Depends on rtms_pkg, rtms_req_if, rtms_rsp_if and rtms_isqrt.
`timescale 1ns / 1ps
//
// Usage:
//   req carries one word per handshake: opposite_leg, adjacent_leg and
//   hypotenuse_len, signed Q8.8 (LENGTH_BITS wide). Exactly one must be zero
//   and the other two positive; the zero side is computed.
//   rsp returns one word per request: side_value (unsigned Q8.8, floor of
//   the square root), which_side and status_code (ok, parameter error, or
//   known leg longer than the hypotenuse).
//   The pipeline has one stage to classify, one to square, one to add or
//   subtract, then one stage per root bit in the square-root pipeline.
//   Throughput is one word per cycle while rsp.ready is high; every stage
//   has its own valid bit. When rsp stalls, stages fill from the back and
//   bubbles are squeezed out; req.ready falls only once every stage holds a
//   word while rsp.ready is low, so nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//
module right_triangle_missing_side
	import rtms_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	rtms_req_if.sink     req,
	rtms_rsp_if.source   rsp
);

	localparam int MW  = LENGTH_BITS - 1;
	localparam int SQW = 2 * MW;
	localparam int RW  = 2 * LENGTH_BITS;

	// stage 1 registers: operand magnitudes and codes
	logic            v_s1;
	logic [MW-1:0]   p_s1;
	logic [MW-1:0]   q_s1;
	logic            sub_s1;
	rtms_tag_t       tag_s1;
	// stage 2 registers: squares
	logic            v_s2;
	logic [SQW-1:0]  pp_s2;
	logic [SQW-1:0]  qq_s2;
	logic            sub_s2;
	rtms_tag_t       tag_s2;
	// stage 3 registers: radicand
	logic            v_s3;
	logic [RW-1:0]   rad_s3;
	rtms_tag_t       tag_s3;

	logic            adv1, adv2, adv3;
	logic            sq_ready;
	logic            sq_valid;
	logic [LENGTH_BITS-1:0] sq_root;
	rtms_tag_t       sq_tag;

	logic [LENGTH_BITS-1:0] o_w, a_w, h_w;
	logic            zo, za, zh, po, pa, ph;
	logic [MW-1:0]   mo, ma, mh;
	logic [MW-1:0]   p_d, q_d;
	logic            sub_d;
	rtms_tag_t       tag_d;
	logic [SQW:0]    rad_d;

	assign adv3 = !v_s3 || sq_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign req.ready = adv1;

	// classify sides and pick the two operands
	always_comb begin
		o_w = req.opposite_leg;
		a_w = req.adjacent_leg;
		h_w = req.hypotenuse_len;
		zo  = (o_w == '0);
		za  = (a_w == '0);
		zh  = (h_w == '0);
		po  = !zo && !o_w[LENGTH_BITS-1];
		pa  = !za && !a_w[LENGTH_BITS-1];
		ph  = !zh && !h_w[LENGTH_BITS-1];
		mo  = o_w[MW-1:0];
		ma  = a_w[MW-1:0];
		mh  = h_w[MW-1:0];
		p_d = '0;
		q_d = '0;
		sub_d = 1'b0;
		tag_d.which  = SIDE_OPP;
		tag_d.status = ST_PARAM;
		if (zo && pa && ph) begin
			tag_d.which = SIDE_OPP;
			if (ma > mh) begin
				tag_d.status = ST_LEG_GT;
			end else begin
				tag_d.status = ST_OK;
				p_d   = mh;
				q_d   = ma;
				sub_d = 1'b1;
			end
		end else if (po && za && ph) begin
			tag_d.which = SIDE_ADJ;
			if (mo > mh) begin
				tag_d.status = ST_LEG_GT;
			end else begin
				tag_d.status = ST_OK;
				p_d   = mh;
				q_d   = mo;
				sub_d = 1'b1;
			end
		end else if (po && pa && zh) begin
			tag_d.which  = SIDE_HYP;
			tag_d.status = ST_OK;
			p_d = mo;
			q_d = ma;
		end
	end

	// sum or difference of the squares
	always_comb begin
		if (sub_s2) begin
			rad_d = {1'b0, pp_s2} - {1'b0, qq_s2};
		end else begin
			rad_d = {1'b0, pp_s2} + {1'b0, qq_s2};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv1) begin
			p_s1   <= p_d;
			q_s1   <= q_d;
			sub_s1 <= sub_d;
			tag_s1 <= tag_d;
		end
		if (adv2) begin
			pp_s2  <= p_s1 * p_s1;
			qq_s2  <= q_s1 * q_s1;
			sub_s2 <= sub_s1;
			tag_s2 <= tag_s1;
		end
		if (adv3) begin
			rad_s3 <= RW'(rad_d);
			tag_s3 <= tag_s2;
		end
	end

	rtms_isqrt #(
		.ROOT_BITS (LENGTH_BITS)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (sq_ready),
		.in_rad    (rad_s3),
		.in_tag    (tag_s3),
		.out_valid (sq_valid),
		.out_ready (rsp.ready),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	assign rsp.valid       = sq_valid;
	assign rsp.side_value  = SIDE_BITS'(sq_root);
	assign rsp.which_side  = sq_tag.which;
	assign rsp.status_code = sq_tag.status;

	// parameter errors leave zero operands and name the opposite side
	a_param_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && tag_s1.status == ST_PARAM) |->
		(p_s1 == '0 && q_s1 == '0 && tag_s1.which == SIDE_OPP))
		else $error("parameter error with live operands");

	// a parameter error reaches the output as zero side, opposite code
	a_param_out: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status_code == ST_PARAM) |->
		(rsp.side_value == '0 && rsp.which_side == SIDE_OPP))
		else $error("parameter error word not cleared");

	// an overlong leg gives a zero side
	a_leg_gt_out: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status_code == ST_LEG_GT) |->
		(rsp.side_value == '0 && rsp.which_side != SIDE_HYP))
		else $error("leg-exceeds word malformed");

endmodule

>>> dv/right_triangle_missing_side_test.sv
// Testbench for right_triangle_missing_side: directed shape table, then random triangles.
// Depends on rtms_pkg, rtms_req_if, rtms_rsp_if and the block's RTL.
`timescale 1ns / 1ps

module right_triangle_missing_side_test;
	import rtms_pkg::*;

	localparam int LENGTH_BITS = 16;
	localparam int LATENCY     = 3 + LENGTH_BITS;
	localparam int RANDOM_WORDS = 2000;

	typedef logic signed [LENGTH_BITS-1:0] len_t;

	// One result word as the block returns it
	typedef struct packed {
		logic [SIDE_BITS-1:0] side;
		logic [CODE_BITS-1:0] which;
		logic [CODE_BITS-1:0] status;
	} side_word_t;

	// Directed row; want is used only when typed is set
	typedef struct {
		len_t       opp;
		len_t       adj;
		len_t       hyp;
		bit         typed;
		side_word_t want;
	} shape_row_t;

	logic clk;
	logic arst_n;

	rtms_req_if #(.LENGTH_BITS(LENGTH_BITS)) req_ch ();
	rtms_rsp_if rsp_ch ();

	right_triangle_missing_side #(
		.LENGTH_BITS(LENGTH_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	side_word_t pending_sides[$];
	int         mismatch_count = 0;
	int         send_idle_pct  = 17;
	int         recv_stall_pct = 17;

	shape_row_t shape_table [22] = '{
		'{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh0300, 16'sh0400, 16'sh0000, 1'b1, '{16'd1280, SIDE_HYP, ST_OK}},
		'{16'sh0000, 16'sh0400, 16'sh0500, 1'b1, '{16'd768,  SIDE_OPP, ST_OK}},
		'{16'sh0300, 16'sh0000, 16'sh0500, 1'b1, '{16'd1024, SIDE_ADJ, ST_OK}},
		// known leg equal to the hypotenuse: zero side, still ok; then two hypotenuse cases
		'{16'sh0000, 16'sh7fff, 16'sh7fff, 1'b1, '{16'd0,    SIDE_OPP, ST_OK}},
		'{16'sh7fff, 16'sh0000, 16'sh7fff, 1'b1, '{16'd0,    SIDE_ADJ, ST_OK}},
		'{16'sh7fff, 16'sh7fff, 16'sh0000, 1'b0, '{16'd0,    SIDE_OPP, ST_OK}},
		'{16'sh0001, 16'sh0001, 16'sh0000, 1'b0, '{16'd0,    SIDE_OPP, ST_OK}},
		// leg longer than hypotenuse
		'{16'sh0000, 16'sh0100, 16'sh0080, 1'b1, '{16'd0,    SIDE_OPP, ST_LEG_GT}},
		'{16'sh7fff, 16'sh0000, 16'sh0001, 1'b1, '{16'd0,    SIDE_ADJ, ST_LEG_GT}},
		// negative sides, too many or too few zeros, and some well-formed triangles
		'{-16'sd1,   16'sh0001, 16'sh0000, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh8000, 16'sh0000, 16'sh0001, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh0001, 16'sh0001, 16'sh0001, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh0000, 16'sh0000, 16'sh0005, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh0005, 16'sh0000, 16'sh0000, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh0000, 16'sh0005, 16'sh0000, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh8000, 16'sh8000, 16'sh8000, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh0000, 16'sh0001, 16'sh7fff, 1'b0, '{16'd0,    SIDE_OPP, ST_OK}},
		'{16'sh0000, -16'sd1,   16'sh0005, 1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh7fff, 16'sh0001, 16'sh0000, 1'b0, '{16'd0,    SIDE_OPP, ST_OK}},
		'{16'sh0000, 16'sh0100, -16'sd1,   1'b1, '{16'd0,    SIDE_OPP, ST_PARAM}},
		'{16'sh1234, 16'sh00ff, 16'sh0000, 1'b0, '{16'd0,    SIDE_OPP, ST_OK}}
	};

	// Floor square root, one result bit per pass from the top
	function automatic logic [SIDE_BITS-1:0] floor_root(longint unsigned radicand);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = SIDE_BITS - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root[SIDE_BITS-1:0];
	endfunction

	// Expected result for one triple of signed Q8.8 sides
	function automatic side_word_t solve_triangle(len_t opp, len_t adj, len_t hyp);
		side_word_t      res;
		longint unsigned om;
		longint unsigned am;
		longint unsigned hm;
		res = '{side: '0, which: SIDE_OPP, status: ST_PARAM};
		om = longint'(opp);
		am = longint'(adj);
		hm = longint'(hyp);
		if (opp == 0 && adj > 0 && hyp > 0) begin
			res.which = SIDE_OPP;
			if (am > hm) begin
				res.status = ST_LEG_GT;
			end else begin
				res.side   = floor_root(hm * hm - am * am);
				res.status = ST_OK;
			end
		end else if (opp > 0 && adj == 0 && hyp > 0) begin
			res.which = SIDE_ADJ;
			if (om > hm) begin
				res.status = ST_LEG_GT;
			end else begin
				res.side   = floor_root(hm * hm - om * om);
				res.status = ST_OK;
			end
		end else if (opp > 0 && adj > 0 && hyp == 0) begin
			res.which  = SIDE_HYP;
			res.side   = floor_root(om * om + am * am);
			res.status = ST_OK;
		end
		return res;
	endfunction

	// Positive length: small, full range, near the top, or a power of two
	function automatic len_t pick_length();
		case ($urandom_range(3))
			0: return len_t'($urandom_range(1, 255));
			1: return len_t'($urandom_range(1, 32767));
			2: return len_t'($urandom_range(32000, 32767));
			default: return len_t'(1 << $urandom_range(0, LENGTH_BITS - 2));
		endcase
	endfunction

	// Drive one word, wait for acceptance, then queue its expected result
	task automatic send_word(len_t opp, len_t adj, len_t hyp, side_word_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.opposite_leg   <= opp;
		req_ch.adjacent_leg   <= adj;
		req_ch.hypotenuse_len <= hyp;
		do @(posedge clk); while (!req_ch.ready);
		pending_sides.push_back(want);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run time limit
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Result sink with random back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		side_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_sides.size() == 0) begin
				$error("result word with no expectation waiting");
				mismatch_count++;
			end else begin
				want = pending_sides.pop_front();
				if (rsp_ch.side_value !== want.side) begin
					$error("side_value: expected %0d, got %0d", want.side, rsp_ch.side_value);
					mismatch_count++;
				end
				if (rsp_ch.which_side !== want.which) begin
					$error("which_side: expected %0d, got %0d", want.which, rsp_ch.which_side);
					mismatch_count++;
				end
				if (rsp_ch.status_code !== want.status) begin
					$error("status_code: expected %0d, got %0d", want.status,
						rsp_ch.status_code);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		len_t       opp;
		len_t       adj;
		len_t       hyp;
		side_word_t want;
		int         kind;

		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.opposite_leg   <= '0;
		req_ch.adjacent_leg   <= '0;
		req_ch.hypotenuse_len <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed shapes
		foreach (shape_table[i]) begin
			want = shape_table[i].typed ? shape_table[i].want :
				solve_triangle(shape_table[i].opp, shape_table[i].adj, shape_table[i].hyp);
			send_word(shape_table[i].opp, shape_table[i].adj, shape_table[i].hyp, want);
		end

		// Random triangles, mostly well formed
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// a stretch with neither side idling
			if (n == 400) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end else if (n == 700) begin
				send_idle_pct  = 17;
				recv_stall_pct = 17;
			end
			// drain fully once mid-run
			if (n == 1000) begin
				req_ch.valid <= 1'b0;
				while (pending_sides.size() != 0) @(posedge clk);
			end

			kind = $urandom_range(99);
			opp  = pick_length();
			adj  = pick_length();
			hyp  = pick_length();
			if (kind < 25) begin
				hyp = '0;
			end else if (kind < 50) begin
				opp = '0;
				if ($urandom_range(9) == 0) adj = hyp;
			end else if (kind < 75) begin
				adj = '0;
				if ($urandom_range(9) == 0) opp = hyp;
			end else if (kind < 87) begin
				// one zero, one negative side
				case ($urandom_range(2))
					0: opp = '0;
					1: adj = '0;
					default: hyp = '0;
				endcase
				case ($urandom_range(2))
					0: if (opp != 0) opp = -opp; else adj = -adj;
					1: if (adj != 0) adj = -adj; else hyp = -hyp;
					default: if (hyp != 0) hyp = -hyp; else opp = -opp;
				endcase
			end else begin
				opp = len_t'($urandom);
				adj = len_t'($urandom);
				hyp = len_t'($urandom);
			end
			send_word(opp, adj, hyp, solve_triangle(opp, adj, hyp));
		end
		req_ch.valid <= 1'b0;

		while (pending_sides.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (mismatch_count == 0 && pending_sides.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
